>>> rtl/core/mqtt_prp_pkg.sv
package mqtt_prp_pkg;

   localparam int unsigned BODY_LEN_W  = 28;
   localparam int unsigned TOPIC_LEN_W = 16;

   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_LENGTH  = 2'd1;
   localparam logic [1:0] PHASE_BODY    = 2'd2;
   localparam logic [1:0] PHASE_DISCARD = 2'd3;

   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;
   localparam logic [3:0] TYPE_SUBACK  = 4'd9;

   localparam logic [2:0] ROLE_HEADER    = 3'd0;
   localparam logic [2:0] ROLE_TOPIC_LEN = 3'd1;
   localparam logic [2:0] ROLE_TOPIC     = 3'd2;
   localparam logic [2:0] ROLE_PAYLOAD   = 3'd3;
   localparam logic [2:0] ROLE_OTHER     = 3'd4;
   localparam logic [2:0] ROLE_DISCARD   = 3'd5;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_PROTOCOL = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
   localparam logic [2:0] STATUS_REFUSED  = 3'd3;
   localparam logic [2:0] STATUS_SUB_FAIL = 3'd4;

   localparam logic CSR_MAX_BODY_LENGTH  = 1'b0;
   localparam logic CSR_MAX_TOPIC_LENGTH = 1'b1;

   localparam logic [BODY_LEN_W-1:0]  MAX_BODY_LENGTH_RESET  = 28'd1024;
   localparam logic [TOPIC_LEN_W-1:0] MAX_TOPIC_LENGTH_RESET = 16'd128;

   localparam logic [7:0] LEN_MORE_MASK  = 8'h80;
   localparam logic [7:0] SUBACK_FAILURE = 8'h80;
   localparam logic [2:0] LEN_BYTES_MAX  = 3'd4;

   typedef logic [BODY_LEN_W-1:0]  body_len_type;
   typedef logic [TOPIC_LEN_W-1:0] topic_len_type;

endpackage

>>> rtl/core/mqtt_packet_receive_parser_core.sv
// A byte accepted on req_ appears on rsp_ in the cycle after it is accepted.
// Throughput: one byte per cycle; the only limit is the result register,
// which takes a new byte whenever it is empty or being emptied.
// Reset (synchronous, active high) returns the parser to waiting for a fixed
// header, clears the connected flag and loads the limit registers' defaults.
module mqtt_packet_receive_parser_core
   import mqtt_prp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [27:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data, [11:8] packet_type, [14:12] status,
                                    // [15] connected
   output logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output logic        rsp_tlast    // packet_end
);

   logic          req_accept;
   logic [7:0]    rx_byte;

   body_len_type  max_body_ff, max_body_in;
   topic_len_type max_topic_ff, max_topic_in;

   logic [1:0]    phase_ff, phase_in;
   logic [3:0]    kind_ff, kind_in;
   body_len_type  accum_ff, accum_in;
   logic [2:0]    len_cnt_ff, len_cnt_in;
   body_len_type  body_cnt_ff, body_cnt_in;
   topic_len_type topic_len_ff, topic_len_in;
   logic [2:0]    pend_ff, pend_in;
   logic          conn_ff, conn_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    role_ff, role_in;
   logic [7:0]    data_ff;
   logic [3:0]    type_ff;
   logic          end_ff, end_in;
   logic [2:0]    status_ff, status_in;
   logic          connected_ff;

   body_len_type  accum_new;
   logic [2:0]    len_cnt_new;
   topic_len_type topic_len_new;
   logic [2:0]    pend_new;
   logic [2:0]    fin_status;
   logic          body_last;

   function automatic logic [2:0] final_status(input logic [3:0] kind,
                                               input body_len_type accum,
                                               input logic [2:0] pend);
      logic [2:0] st;
      st = pend;
      if (kind == TYPE_CONNACK && accum < 28'd2) st = STATUS_PROTOCOL;
      if (kind == TYPE_SUBACK && accum < 28'd3) st = STATUS_PROTOCOL;
      if (kind == TYPE_PUBLISH && accum < 28'd2) st = STATUS_PROTOCOL;
      return st;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;
   assign body_last  = ({1'b0, body_cnt_ff} + 29'd1) >= {1'b0, accum_ff};

   always_comb begin
      max_body_in  = max_body_ff;
      max_topic_in = max_topic_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_BODY_LENGTH: max_body_in = csr_wdata;
            CSR_MAX_TOPIC_LENGTH: max_topic_in = csr_wdata[TOPIC_LEN_W-1:0];
            default: max_body_in = max_body_ff;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      accum_in      = accum_ff;
      len_cnt_in    = len_cnt_ff;
      body_cnt_in   = body_cnt_ff;
      topic_len_in  = topic_len_ff;
      pend_in       = pend_ff;
      conn_in       = conn_ff;
      role_in       = ROLE_HEADER;
      end_in        = 1'b0;
      status_in     = STATUS_OK;
      fin_status    = STATUS_OK;
      accum_new     = accum_ff | ({21'd0, rx_byte[6:0]} << (5'd7 * {3'd0, len_cnt_ff[1:0]}));
      len_cnt_new   = len_cnt_ff + 3'd1;
      topic_len_new = topic_len_ff;
      pend_new      = pend_ff;

      if (req_accept) begin
         if (req_tuser) begin
            phase_in     = PHASE_HEADER;
            kind_in      = 4'd0;
            accum_in     = '0;
            len_cnt_in   = 3'd0;
            body_cnt_in  = '0;
            topic_len_in = '0;
            pend_in      = STATUS_OK;
            role_in      = ROLE_DISCARD;
         end else begin
            case (phase_ff)
               PHASE_HEADER: begin
                  kind_in      = rx_byte[7:4];
                  accum_in     = '0;
                  len_cnt_in   = 3'd0;
                  body_cnt_in  = '0;
                  topic_len_in = '0;
                  pend_in      = STATUS_OK;
                  phase_in     = PHASE_LENGTH;
               end
               PHASE_LENGTH: begin
                  accum_in   = accum_new;
                  len_cnt_in = len_cnt_new;
                  if (!((rx_byte & LEN_MORE_MASK) != 8'd0 && len_cnt_new < LEN_BYTES_MAX)) begin
                     body_cnt_in  = '0;
                     topic_len_in = '0;
                     pend_in      = STATUS_OK;
                     if (accum_new == '0) begin
                        fin_status = final_status(kind_ff, accum_new, STATUS_OK);
                        end_in     = 1'b1;
                        status_in  = fin_status;
                        phase_in   = PHASE_HEADER;
                        if (kind_ff == TYPE_CONNACK) conn_in = (fin_status == STATUS_OK);
                     end else if (accum_new > max_body_ff) begin
                        pend_in  = STATUS_TOO_LONG;
                        phase_in = PHASE_DISCARD;
                     end else begin
                        phase_in = PHASE_BODY;
                     end
                  end
               end
               PHASE_BODY: begin
                  role_in = ROLE_OTHER;
                  if (kind_ff == TYPE_PUBLISH) begin
                     if (body_cnt_ff < 28'd2) begin
                        role_in       = ROLE_TOPIC_LEN;
                        topic_len_new = {topic_len_ff[7:0], rx_byte};
                        if (body_cnt_ff == 28'd1 &&
                            (topic_len_new >= max_topic_ff ||
                             {11'd0, {1'b0, topic_len_new} + 17'd2} > accum_ff)) begin
                           pend_new = STATUS_PROTOCOL;
                        end
                     end else if (pend_ff == STATUS_OK) begin
                        role_in = (body_cnt_ff < {11'd0, {1'b0, topic_len_ff} + 17'd2}) ?
                                  ROLE_TOPIC : ROLE_PAYLOAD;
                     end
                  end else if (kind_ff == TYPE_CONNACK) begin
                     if (body_cnt_ff == 28'd1 && rx_byte != 8'd0) pend_new = STATUS_REFUSED;
                  end else if (kind_ff == TYPE_SUBACK) begin
                     if (body_cnt_ff == 28'd2 && rx_byte == SUBACK_FAILURE) begin
                        pend_new = STATUS_SUB_FAIL;
                     end
                  end
                  topic_len_in = topic_len_new;
                  pend_in      = pend_new;
                  if (body_last) begin
                     fin_status = final_status(kind_ff, accum_ff, pend_new);
                     end_in     = 1'b1;
                     status_in  = fin_status;
                     phase_in   = PHASE_HEADER;
                     pend_in    = STATUS_OK;
                     if (kind_ff == TYPE_CONNACK) conn_in = (fin_status == STATUS_OK);
                  end else begin
                     body_cnt_in = body_cnt_ff + 28'd1;
                  end
               end
               default: begin
                  role_in = ROLE_DISCARD;
                  if (body_last) begin
                     end_in    = 1'b1;
                     status_in = STATUS_TOO_LONG;
                     phase_in  = PHASE_HEADER;
                     pend_in   = STATUS_OK;
                     if (kind_ff == TYPE_CONNACK) conn_in = 1'b0;
                  end else begin
                     body_cnt_in = body_cnt_ff + 28'd1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff  <= MAX_BODY_LENGTH_RESET;
         max_topic_ff <= MAX_TOPIC_LENGTH_RESET;
         phase_ff     <= PHASE_HEADER;
         kind_ff      <= 4'd0;
         accum_ff     <= '0;
         len_cnt_ff   <= 3'd0;
         body_cnt_ff  <= '0;
         topic_len_ff <= '0;
         pend_ff      <= STATUS_OK;
         conn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_body_ff  <= max_body_in;
         max_topic_ff <= max_topic_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         accum_ff     <= accum_in;
         len_cnt_ff   <= len_cnt_in;
         body_cnt_ff  <= body_cnt_in;
         topic_len_ff <= topic_len_in;
         pend_ff      <= pend_in;
         conn_ff      <= conn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         role_ff      <= role_in;
         data_ff      <= rx_byte;
         type_ff      <= kind_in;
         end_ff       <= end_in;
         status_ff    <= status_in;
         connected_ff <= conn_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {connected_ff, status_ff, type_ff, data_ff};
   assign rsp_tuser  = role_ff;
   assign rsp_tlast  = end_ff;

   // A restart transaction always yields a discarded, non-final result.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> rsp_tvalid && rsp_tuser == ROLE_DISCARD && !rsp_tlast)
      else $error("restart did not produce a discarded result");

   // The length field never runs past its fourth byte.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_LENGTH |-> len_cnt_ff < LEN_BYTES_MAX)
      else $error("length byte count overran");

   // Topic bytes only occur inside a PUBLISH packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ROLE_TOPIC || rsp_tuser == ROLE_TOPIC_LEN) |->
      rsp_tdata[11:8] == TYPE_PUBLISH)
      else $error("topic role outside PUBLISH");

   // A status other than ok is only reported on the last byte of a packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[14:12] == STATUS_OK)
      else $error("status reported before packet end");

endmodule
